// ===== hw/rtl/rrts_pkg.sv =====
package rrts_pkg;

  // Default table size.
  localparam int MAX_TASKS_DEF = 8;

  // Field widths of the channels.
  localparam int MODE_W = 4;
  localparam int DLY_W  = 16;
  localparam int TASK_W = 3;
  localparam int USE_W  = 4;

  // Internal widths.
  localparam int TICK_W = 10;
  localparam int ISR_W  = 8;
  localparam int STAT_W = 2;
  localparam int DCNT_W = $clog2(DLY_W);

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [TICK_W-1:0] TICK_RST = TICK_W'(20);

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_CREATE  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_TICK    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_YIELD   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DELAY   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_SETDLY  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_EXIT    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_ISR_IN  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_ISR_OUT = 4'd7;
  localparam logic [MODE_W-1:0] MODE_RUN     = 4'd8;

  // Slot status codes.
  localparam logic [STAT_W-1:0] ST_READY  = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZOMBIE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic set_err;
    logic create;
    logic isr_inc;
    logic isr_dec;
    logic ptr_zero;
    logic ptr_run;
    logic rd;
    logic rd_wrap;
    logic tick_upd;
    logic yield_upd;
    logic div_start;
    logic div_step;
    logic dly_wr;
    logic exit_wr;
    logic sch_init;
    logic first_disp;
    logic commit_ptr;
    logic commit_idle;
    logic out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic have;
    logic total_zero;
    logic one_task;
    logic isr_busy;
    logic tick_last;
    logic hit;
    logic walk_end;
    logic div_last;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== hw/rtl/rrts_if.sv =====
// Command channel.
interface rrts_in_if;
  logic                        valid;
  logic                        ready;
  logic [rrts_pkg::MODE_W-1:0] mode;
  logic [rrts_pkg::DLY_W-1:0]  delay_ms;

  modport source (output valid, mode, delay_ms, input ready);
  modport sink   (input valid, mode, delay_ms, output ready);
endinterface

// Result channel.
interface rrts_out_if;
  logic                        valid;
  logic                        ready;
  logic [rrts_pkg::TASK_W-1:0] running_task;
  logic                        running_valid;
  logic                        switched;
  logic                        error;
  logic [rrts_pkg::USE_W-1:0]  tasks_in_use;

  modport source (output valid, running_task, running_valid, switched, error, tasks_in_use,
                  input ready);
  modport sink   (input valid, running_task, running_valid, switched, error, tasks_in_use,
                  output ready);
endinterface

// ===== hw/rtl/rrts_ram.sv =====
module rrts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/rrts_ctrl.sv =====
module rrts_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rrts_pkg::MODE_W-1:0] in_mode,
  input  rrts_pkg::ctl_sts_t          sts,
  output rrts_pkg::ctl_cmd_t          cmd
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_DECODE  = 10'b0000000010,
    S_RD      = 10'b0000000100,
    S_UPD     = 10'b0000001000,
    S_DIV     = 10'b0000010000,
    S_DLY_WR  = 10'b0000100000,
    S_SCH_INI = 10'b0001000000,
    S_SCH_RD  = 10'b0010000000,
    S_SCH_CHK = 10'b0100000000,
    S_FIN     = 10'b1000000000
  } ctl_state_t;

  ctl_state_t                  state_r, state_nxt;
  logic [rrts_pkg::MODE_W-1:0] mode_r;

  assign in_ready = (state_r == S_IDLE);

  // Command code of the item in work.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencing of one item.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (mode_r)
          rrts_pkg::MODE_CREATE: begin
            if (sts.full) begin
              cmd.set_err = 1'b1;
            end else begin
              cmd.create = 1'b1;
            end
            state_nxt = S_FIN;
          end
          rrts_pkg::MODE_TICK: begin
            if (sts.total_zero) begin
              state_nxt = S_SCH_INI;
            end else begin
              cmd.ptr_zero = 1'b1;
              state_nxt    = S_RD;
            end
          end
          rrts_pkg::MODE_YIELD: begin
            if (!sts.have) begin
              cmd.set_err = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              cmd.ptr_run = 1'b1;
              state_nxt   = S_RD;
            end
          end
          rrts_pkg::MODE_DELAY, rrts_pkg::MODE_SETDLY: begin
            if (!sts.have) begin
              cmd.set_err = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          rrts_pkg::MODE_EXIT: begin
            if (!sts.have) begin
              cmd.set_err = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              cmd.exit_wr = 1'b1;
              state_nxt   = S_SCH_INI;
            end
          end
          rrts_pkg::MODE_ISR_IN: begin
            cmd.isr_inc = 1'b1;
            state_nxt   = S_FIN;
          end
          rrts_pkg::MODE_ISR_OUT: begin
            cmd.isr_dec = 1'b1;
            state_nxt   = S_SCH_INI;
          end
          rrts_pkg::MODE_RUN: begin
            state_nxt = S_SCH_INI;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (mode_r == rrts_pkg::MODE_TICK) begin
          cmd.tick_upd = 1'b1;
          state_nxt    = sts.tick_last ? S_SCH_INI : S_RD;
        end else begin
          cmd.yield_upd = 1'b1;
          state_nxt     = S_SCH_INI;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DLY_WR;
        end
      end
      S_DLY_WR: begin
        cmd.dly_wr = 1'b1;
        state_nxt  = (mode_r == rrts_pkg::MODE_DELAY) ? S_SCH_INI : S_FIN;
      end
      S_SCH_INI: begin
        // No dispatch inside an ISR or with an empty table; a lone task stays.
        if (sts.isr_busy || sts.total_zero) begin
          state_nxt = S_FIN;
        end else if (!sts.have) begin
          cmd.first_disp = 1'b1;
          state_nxt      = S_FIN;
        end else if (sts.one_task) begin
          state_nxt = S_FIN;
        end else begin
          cmd.sch_init = 1'b1;
          state_nxt    = S_SCH_RD;
        end
      end
      S_SCH_RD: begin
        cmd.rd_wrap = 1'b1;
        state_nxt   = S_SCH_CHK;
      end
      S_SCH_CHK: begin
        if (sts.hit) begin
          cmd.commit_ptr = 1'b1;
          state_nxt      = S_FIN;
        end else if (sts.walk_end) begin
          cmd.commit_idle = 1'b1;
          state_nxt       = S_FIN;
        end else begin
          state_nxt = S_SCH_RD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rrts_dp.sv =====
module rrts_dp #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrts_pkg::ctl_cmd_t          cmd,
  output rrts_pkg::ctl_sts_t          sts,
  input  logic [rrts_pkg::DLY_W-1:0]  in_delay_ms,
  input  logic [rrts_pkg::TICK_W-1:0] tick_period,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rrts_pkg::TASK_W-1:0] out_running_task,
  output logic                        out_running_valid,
  output logic                        out_switched,
  output logic                        out_error,
  output logic [rrts_pkg::USE_W-1:0]  out_tasks_in_use
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = IDX_W + 1;
  localparam int DLY_W = rrts_pkg::DLY_W;
  localparam int TK_W  = rrts_pkg::TICK_W;
  localparam int ISR_W = rrts_pkg::ISR_W;
  localparam int ST_W  = rrts_pkg::STAT_W;
  localparam int DC_W  = rrts_pkg::DCNT_W;
  localparam logic [DC_W-1:0] DIV_LAST = DC_W'(DLY_W - 1);

  logic [CNT_W-1:0] total_r;
  logic [IDX_W-1:0] run_idx_r;
  logic             run_flag_r;
  logic [ISR_W-1:0] isr_r;
  logic [IDX_W-1:0] ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             sw_r;
  logic             err_r;

  logic [DLY_W-1:0] quo_r;
  logic [TK_W-1:0]  rem_r;
  logic [TK_W-1:0]  dvs_r;
  logic [DC_W-1:0]  div_cnt_r;

  logic                        out_valid_r;
  logic [rrts_pkg::TASK_W-1:0] o_task_r;
  logic                        o_rv_r;
  logic                        o_sw_r;
  logic                        o_err_r;
  logic [rrts_pkg::USE_W-1:0]  o_use_r;

  logic [IDX_W-1:0] total_idx;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] ptr_wrap;
  logic [CNT_W-1:0] ptr_inc;
  logic [ST_W-1:0]  st_rd;
  logic [DLY_W-1:0] wt_rd;
  logic             st_ready;
  logic             wt_zero;

  logic             st_we;
  logic [IDX_W-1:0] st_waddr;
  logic [ST_W-1:0]  st_wdata;
  logic             wt_we;
  logic [IDX_W-1:0] wt_waddr;
  logic [DLY_W-1:0] wt_wdata;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  logic [TK_W:0]    rem_sh;
  logic [TK_W:0]    dvs_ext;
  logic             q_bit;
  logic [TK_W:0]    rem_diff;

  logic [IDX_W-1:0] pick;
  logic             commit;
  logic [IDX_W+2:0] idx_ext;
  logic [CNT_W+3:0] total_ext;

  // Ring positions derived from the fill count.
  assign total_idx = total_r[IDX_W-1:0];
  assign last_idx  = total_idx - IDX_W'(1);
  assign ptr_wrap  = (ptr_r == '0) ? last_idx : (ptr_r - IDX_W'(1));
  assign ptr_inc   = {1'b0, ptr_r} + CNT_W'(1);

  // Slot fields read back from the tables.
  assign st_ready = (st_rd == rrts_pkg::ST_READY);
  assign wt_zero  = (wt_rd == '0);

  // Table write and read selection.
  always_comb begin
    st_we    = cmd.create || cmd.exit_wr;
    st_waddr = cmd.create ? total_idx : run_idx_r;
    st_wdata = cmd.create ? rrts_pkg::ST_READY : rrts_pkg::ST_ZOMBIE;

    wt_we = cmd.create || cmd.dly_wr
         || (cmd.tick_upd && st_ready && !wt_zero)
         || (cmd.yield_upd && wt_zero);
    if (cmd.create) begin
      wt_waddr = total_idx;
      wt_wdata = '0;
    end else if (cmd.dly_wr) begin
      wt_waddr = run_idx_r;
      wt_wdata = quo_r;
    end else if (cmd.tick_upd) begin
      wt_waddr = ptr_r;
      wt_wdata = wt_rd - DLY_W'(1);
    end else begin
      wt_waddr = ptr_r;
      wt_wdata = DLY_W'(1);
    end

    rd_en   = cmd.rd || cmd.rd_wrap;
    rd_addr = cmd.rd_wrap ? ptr_wrap : ptr_r;
  end

  rrts_ram #(
    .WIDTH (ST_W),
    .DEPTH (MAX_TASKS)
  ) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (st_rd)
  );

  rrts_ram #(
    .WIDTH (DLY_W),
    .DEPTH (MAX_TASKS)
  ) u_wt_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (wt_rd)
  );

  // Restoring divider step, one quotient bit per cycle.
  assign rem_sh   = {rem_r, quo_r[DLY_W-1]};
  assign dvs_ext  = {1'b0, dvs_r};
  assign q_bit    = (rem_sh >= dvs_ext);
  assign rem_diff = rem_sh - dvs_ext;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      quo_r <= in_delay_ms;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[DLY_W-2:0], q_bit};
    end
    if (cmd.div_start) begin
      rem_r     <= '0;
      div_cnt_r <= '0;
      dvs_r     <= (tick_period == '0) ? TK_W'(1) : tick_period;
    end else if (cmd.div_step) begin
      rem_r     <= q_bit ? rem_diff[TK_W-1:0] : rem_sh[TK_W-1:0];
      div_cnt_r <= div_cnt_r + DC_W'(1);
    end
  end

  // Walk pointer and step count.
  always_ff @(posedge clk) begin
    if (cmd.ptr_zero) begin
      ptr_r <= '0;
    end else if (cmd.ptr_run || cmd.sch_init) begin
      ptr_r <= run_idx_r;
    end else if (cmd.tick_upd) begin
      ptr_r <= ptr_inc[IDX_W-1:0];
    end else if (cmd.rd_wrap) begin
      ptr_r <= ptr_wrap;
    end
    if (cmd.sch_init) begin
      cnt_r <= CNT_W'(1);
    end else if (cmd.rd_wrap) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Dispatch choice of the schedule step.
  assign pick   = cmd.commit_ptr ? ptr_r : '0;
  assign commit = cmd.commit_ptr || cmd.commit_idle;

  // Scheduler state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      run_idx_r  <= '0;
      run_flag_r <= 1'b0;
      isr_r      <= '0;
      sw_r       <= 1'b0;
      err_r      <= 1'b0;
    end else begin
      if (cmd.create) begin
        total_r <= total_r + CNT_W'(1);
      end
      if (cmd.isr_inc && (isr_r != '1)) begin
        isr_r <= isr_r + ISR_W'(1);
      end else if (cmd.isr_dec && (isr_r != '0)) begin
        isr_r <= isr_r - ISR_W'(1);
      end
      if (cmd.accept) begin
        sw_r  <= 1'b0;
        err_r <= 1'b0;
      end else if (cmd.set_err) begin
        err_r <= 1'b1;
      end
      if (cmd.first_disp) begin
        run_idx_r  <= last_idx;
        run_flag_r <= 1'b1;
        sw_r       <= 1'b1;
      end else if (commit && (pick != run_idx_r)) begin
        run_idx_r <= pick;
        sw_r      <= 1'b1;
      end
    end
  end

  // Result register, free again once the item is taken.
  assign idx_ext   = {3'b000, run_idx_r};
  assign total_ext = {4'b0000, total_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_task_r <= idx_ext[rrts_pkg::TASK_W-1:0];
      o_rv_r   <= run_flag_r;
      o_sw_r   <= sw_r;
      o_err_r  <= err_r;
      o_use_r  <= total_ext[rrts_pkg::USE_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_running_task  = o_task_r;
  assign out_running_valid = o_rv_r;
  assign out_switched      = o_sw_r;
  assign out_error         = o_err_r;
  assign out_tasks_in_use  = o_use_r;

  // Status to the controller.
  always_comb begin
    sts            = '0;
    sts.full       = (total_r == CNT_W'(MAX_TASKS));
    sts.have       = run_flag_r;
    sts.total_zero = (total_r == '0);
    sts.one_task   = (total_r == CNT_W'(1));
    sts.isr_busy   = (isr_r != '0);
    sts.tick_last  = (ptr_inc == total_r);
    sts.hit        = (ptr_r != '0) && st_ready && wt_zero;
    sts.walk_end   = (cnt_r == total_r);
    sts.div_last   = (div_cnt_r == DIV_LAST);
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

// ===== hw/rtl/round_robin_task_scheduler_top.sv =====
// Channel   Dir  Handshake         Payload
// in_chan   in   valid/ready       mode, delay_ms
// out_chan  out  valid/ready       running_task, running_valid, switched, error,
//                                  tasks_in_use
// config    in   APB (psel..)      tick_period_ms at byte address 0
//
// One item at a time; a new item is taken once the previous one is in the result
// register. Create, ISR enter and unused codes go from decode straight to the result
// step; delay also runs the bit-serial divider. Tick reads and updates each created
// slot in turn and the schedule walk reads and checks each slot visited, both paced
// by the single read port of the slot tables. Reset is synchronous and the
// slot tables need no clearing pass. A stalled result holds the block until taken.
module round_robin_task_scheduler_top #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rrts_in_if.sink                     in_chan,
  rrts_out_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrts_pkg::APB_AW-1:0] paddr,
  input  logic [rrts_pkg::APB_DW-1:0] pwdata,
  output logic [rrts_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int TK_W = rrts_pkg::TICK_W;

  logic [TK_W-1:0]    tick_r;
  logic               reg_sel;
  rrts_pkg::ctl_cmd_t cmd;
  rrts_pkg::ctl_sts_t sts;

  // Tick period register.
  assign pready  = 1'b1;
  assign reg_sel = !paddr[rrts_pkg::APB_AW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= rrts_pkg::TICK_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      tick_r <= pwdata[TK_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(rrts_pkg::APB_DW - TK_W){1'b0}}, tick_r} : '0;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_mode  (in_chan.mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_delay_ms       (in_chan.delay_ms),
    .tick_period       (tick_r),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_running_task  (out_chan.running_task),
    .out_running_valid (out_chan.running_valid),
    .out_switched      (out_chan.switched),
    .out_error         (out_chan.error),
    .out_tasks_in_use  (out_chan.tasks_in_use)
  );

endmodule
